### sv/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg : shared types and constants for the sobel edge magnitude block
// pixel and index types, register map codes and the window gradient function
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  localparam int unsigned PIXEL_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [PIXEL_W-1:0]   pixel_t;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;

  // register map
  localparam cfg_index_t REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam cfg_index_t REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // saturation limit of the edge magnitude
  localparam logic [9:0] EDGE_MAX = 10'd255;

  // flags carried with a word from the counter stage to the window stage
  typedef struct packed {
    logic result;
    logic last;
  } word_flags_t;

  // gradient magnitude over the window, corners weight one, edge centres halved
  function automatic pixel_t edge_mag(input pixel_t lt, input pixel_t lm,
                                      input pixel_t lb, input pixel_t mt,
                                      input pixel_t mb, input pixel_t rt,
                                      input pixel_t rm, input pixel_t rb);
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [10:0]        ax;
    logic [10:0]        ay;
    logic [11:0]        sum;
    logic [9:0]         g;
    gx = $signed({3'b000, lt}) + $signed({4'b0000, lm[7:1]}) + $signed({3'b000, lb})
       - $signed({3'b000, rb}) - $signed({4'b0000, rm[7:1]}) - $signed({3'b000, rt});
    gy = $signed({3'b000, rt}) + $signed({4'b0000, mt[7:1]}) + $signed({3'b000, lt})
       - $signed({3'b000, rb}) - $signed({4'b0000, mb[7:1]}) - $signed({3'b000, lb});
    ax  = gx[10] ? 11'(-gx) : 11'(gx);
    ay  = gy[10] ? 11'(-gy) : 11'(gy);
    sum = {1'b0, ax} + {1'b0, ay};
    g   = sum[11:2];
    return (g > EDGE_MAX) ? pixel_t'(EDGE_MAX) : g[7:0];
  endfunction

endpackage

`default_nettype wire

### sv/sobel_edge_magnitude_3x3.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3 : streaming 3x3 edge magnitude
// raster pixels in, one saturated edge word out for each interior pixel
// ----------------------------------------------------------------------------
// The block takes one pixel per clock for as long as the output side takes
// its words; the pixel that completes a window loads the window stage
// register on its accepting edge, together with the synchronous line store
// reads, and its edge word loads the output register when the window stage
// moves. With the output stalled the block holds two words, one in the window
// stage and one in the output register, before it drops in_ready. The two line
// stores are single memories with one read and one write each per cycle; a
// word that reads an entry being written back in the same cycle (image width
// of one or less) takes the value by forwarding. Border pixels give no output,
// so an image of W by H gives (W-2) by (H-2) words, the last flagged by
// last_of_image. A write to the width or height register restarts the frame at
// row 0, column 0; a write to any other index does nothing. Write registers
// only while the block is idle. Line stores need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_3x3
  import sem_pkg::*;
#(
  parameter int unsigned MAX_LINE_PIXELS = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // pixel input
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire pixel_t     pixel,
  // edge output
  output logic            out_valid,
  input  wire logic       out_ready,
  output pixel_t          edge_value,
  output logic            last_of_image,
  // register writes
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire cfg_index_t cfg_index,
  input  wire pixel_t     cfg_data
);

  localparam int unsigned IDX_W = $clog2(MAX_LINE_PIXELS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_LINE_PIXELS - 1);

  // configuration and raster position
  pixel_t           image_width;
  pixel_t           image_height;
  pixel_t           col;
  pixel_t           row;
  logic [IDX_W-1:0] idx;

  // window stage
  logic             s1_valid;
  word_flags_t      s1_flags;
  pixel_t           s1_pixel;
  logic [IDX_W-1:0] s1_idx;
  logic             s1_fwd;
  pixel_t           fwd_rt;
  pixel_t           fwd_rm;

  // line stores and their read data
  pixel_t           line_prev  [MAX_LINE_PIXELS];
  pixel_t           line_older [MAX_LINE_PIXELS];
  pixel_t           prev_q;
  pixel_t           older_q;

  // window of the two previous columns
  pixel_t           win [6];

  logic             in_fire;
  logic             s1_fire;
  logic             cfg_fire;
  logic             cfg_hit;
  logic             col_last;
  logic             row_last;
  word_flags_t      acc_flags;
  pixel_t           rt_eff;
  pixel_t           rm_eff;
  pixel_t           edge_next;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire &&
                     (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

  // handshake: window stage moves when its word gives no output or the output register can take it
  assign s1_fire  = s1_valid && (!s1_flags.result || !out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // raster position compares
  assign col_last = ({1'b0, col} + 9'd1) >= {1'b0, image_width};
  assign row_last = ({1'b0, row} + 9'd1) >= {1'b0, image_height};
  assign acc_flags.result = (row >= 8'd2) && (col >= 8'd2);
  assign acc_flags.last   = col_last && row_last;

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 8'd255;
      image_height <= 8'd255;
    end else if (cfg_fire) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end
      if (cfg_index == REG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  // raster counters, store index wraps at the store depth
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col <= '0;
      row <= '0;
      idx <= '0;
    end else if (in_fire) begin
      if (col_last) begin
        col <= '0;
        idx <= '0;
        row <= row_last ? 8'd0 : row + 8'd1;
      end else begin
        col <= col + 8'd1;
        idx <= (idx == IDX_LAST) ? '0 : idx + 1'b1;
      end
    end
  end

  // line store memories: read on accept, write back when the window stage moves
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_prev[s1_idx] <= s1_pixel;
    end
    if (in_fire) begin
      prev_q <= line_prev[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_older[s1_idx] <= rm_eff;
    end
    if (in_fire) begin
      older_q <= line_older[idx];
    end
  end

  // forwarded column when the same entry is written as it is read
  assign rt_eff = s1_fwd ? fwd_rt : older_q;
  assign rm_eff = s1_fwd ? fwd_rm : prev_q;

  // window stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // window stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_flags <= acc_flags;
      s1_pixel <= pixel;
      s1_idx   <= idx;
      s1_fwd   <= s1_fire && (s1_idx == idx);
      fwd_rt   <= rm_eff;
      fwd_rm   <= s1_pixel;
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (s1_fire) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= rt_eff;
      win[4] <= rm_eff;
      win[5] <= s1_pixel;
    end
  end

  // gradient magnitude
  assign edge_next = edge_mag(win[0], win[1], win[2], win[3], win[5],
                              rt_eff, rm_eff, s1_pixel);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_flags.result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_flags.result) begin
      edge_value    <= edge_next;
      last_of_image <= s1_flags.last;
    end
  end

  // checks
  a_s1_holds : assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_fire |=> s1_valid)
    else $error("window stage lost a word while stalled");

  a_frame_wrap : assert property (@(posedge clk) disable iff (rst)
    in_fire && acc_flags.last |=> col == 8'd0 && row == 8'd0)
    else $error("raster position did not wrap after the last pixel");

  a_idx_start : assert property (@(posedge clk) disable iff (rst)
    col == 8'd0 |-> idx == '0)
    else $error("store index out of step with column");

  a_out_source : assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("output word without a word in the window stage");

endmodule

`default_nettype wire
